### rtl/ktt_pkg.sv
package ktt_pkg;

	localparam logic [2:0] CMD_SET   = 3'd0;
	localparam logic [2:0] CMD_KILL  = 3'd1;
	localparam logic [2:0] CMD_ADD   = 3'd2;
	localparam logic [2:0] CMD_QUERY = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_DISABLED = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// Operations handed from the front part to the back part.
	localparam logic [2:0] OP_SET    = 3'd0;
	localparam logic [2:0] OP_KILL   = 3'd1;
	localparam logic [2:0] OP_ADD    = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;
	localparam logic [2:0] OP_STATUS = 3'd5;

	typedef struct packed {
		logic [2:0]         command;
		logic [15:0]        id_first;
		logic [15:0]        id_second;
		logic [15:0]        id_third;
		logic [15:0]        timer_id;
		logic signed [31:0] delay_ticks;
		logic [63:0]        user_data;
	} in_t;

	typedef struct packed {
		logic               kind;
		logic [1:0]         status;
		logic [15:0]        out_id_first;
		logic [15:0]        out_id_second;
		logic [15:0]        out_id_third;
		logic [15:0]        out_timer_id;
		logic [63:0]        out_data;
		logic signed [31:0] remaining;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         st;
		logic [63:0]        key;
		logic signed [31:0] delay;
		logic [63:0]        data;
	} cmd_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [32:0] sum;
		sum = {a[31], a} + {b[31], b};
		if (sum[32] != sum[31]) begin
			sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_add = sum[31:0];
		end
	endfunction

endpackage

### rtl/keyed_oneshot_timer_table_top.sv
// A status word is registered at the output once a scan of every slot has found its result,
// or without a scan for an unknown command or a disabled command other than kill.
// The back part handles one command at a time; the two-entry queue takes new words while it has room.
// A tick counts every slot down, then emits one expiry word per due slot, lowest key first.
// Reset (arst_n low, asynchronous) empties the table, the queue and the output register,
// and clears the enabled register. Slot contents are not cleared.
module keyed_oneshot_timer_table_top
	import ktt_pkg::*;
#(
	parameter int TIMER_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_word,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_word,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	// The enabled register is read only by the front part, which folds it
	// into the operation it queues.
	logic enabled_q;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t wr_entry;
	cmd_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	// The front part takes a word whenever the queue has room.
	ktt_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.enabled  (enabled_q),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	// A two-entry queue lets the front side keep accepting while the back
	// side is busy scanning or waiting on its output.
	ktt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	// The back part walks the slots one per cycle and drives the output
	// register.
	ktt_back #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.rd_entry  (rd_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

### rtl/ktt_front.sv
module ktt_front
	import ktt_pkg::*;
(
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_word,
	input  logic enabled,
	input  logic q_full,
	output logic push,
	output cmd_t entry
);

	// Classify each word once, so the back part only sees work it must do.
	always_comb begin
		entry.key   = {in_word.timer_id, in_word.id_third, in_word.id_second,
			in_word.id_first};
		entry.delay = in_word.delay_ticks;
		entry.data  = in_word.user_data;
		entry.st    = ST_OK;
		entry.op    = OP_STATUS;
		if (in_word.command == CMD_KILL) begin
			entry.op = OP_KILL;
		end else if (in_word.command > CMD_TICK) begin
			entry.op = OP_STATUS;
		end else if (!enabled) begin
			entry.st = ST_DISABLED;
		end else begin
			case (in_word.command)
				CMD_SET:   entry.op = OP_SET;
				CMD_ADD:   entry.op = OP_ADD;
				CMD_QUERY: entry.op = OP_QUERY;
				CMD_TICK:  entry.op = OP_TICK;
				default:   entry.op = OP_STATUS;
			endcase
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

### rtl/ktt_queue.sv
module ktt_queue
	import ktt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_entry,
	input  logic pop,
	output cmd_t rd_entry,
	output logic full,
	output logic empty
);

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign rd_entry = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_entry;
		end
	end

endmodule

### rtl/ktt_back.sv
module ktt_back
	import ktt_pkg::*;
#(
	parameter int TIMER_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  cmd_t rd_entry,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_word
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_MIN  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]             state_q;
	logic [IW-1:0]          idx_q;
	cmd_t                   cmd_q;
	logic                   found_q;
	logic                   free_q;
	logic [IW-1:0]          hit_q;
	logic [IW-1:0]          free_idx_q;
	logic                   best_ok_q;
	logic [63:0]            best_key_q;
	logic [IW-1:0]          best_q;
	logic [TIMER_SLOTS-1:0] due_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic                   out_vld_q;
	out_t                   out_q;

	logic [63:0]        key_mem  [TIMER_SLOTS];
	logic signed [31:0] cnt_mem  [TIMER_SLOTS];
	logic [63:0]        data_mem [TIMER_SLOTS];

	logic [63:0]        key_rd;
	logic signed [31:0] cnt_rd;
	logic [63:0]        data_rd;
	logic               at_last;
	logic               out_free;
	logic               out_load;
	out_t               out_nxt;
	logic               match;
	logic               nxt_found;
	logic               nxt_free;
	logic [IW-1:0]      nxt_hit;
	logic [IW-1:0]      nxt_free_idx;
	logic signed [31:0] dec_val;
	logic               dec_due;
	logic               better;

	assign key_rd   = key_mem[idx_q];
	assign cnt_rd   = cnt_mem[idx_q];
	assign data_rd  = data_mem[idx_q];
	assign at_last  = idx_q == LAST_IDX;
	assign out_free = !out_vld_q || !out_stall;
	assign out_load = out_free && (state_q == S_EXEC || state_q == S_EMIT);
	assign pop      = state_q == S_IDLE && !empty;

	assign match        = valid_q[idx_q] && key_rd == cmd_q.key;
	assign nxt_found    = found_q || match;
	assign nxt_hit      = found_q ? hit_q : idx_q;
	assign nxt_free     = free_q || !valid_q[idx_q];
	assign nxt_free_idx = free_q ? free_idx_q : idx_q;
	assign dec_val      = sat_add(cnt_rd, -32'sd1);
	assign dec_due      = valid_q[idx_q] && dec_val <= 32'sd0;
	assign better       = due_q[idx_q] && (!best_ok_q || key_rd < best_key_q);

	assign out_valid = out_vld_q;
	assign out_word  = out_q;

	// The next output word, for a status result or for an expiry.
	always_comb begin
		out_nxt      = '0;
		out_nxt.kind = KIND_STATUS;
		out_nxt.last = 1'b1;
		if (state_q == S_EMIT) begin
			out_nxt.kind          = KIND_EXPIRY;
			out_nxt.status        = ST_OK;
			out_nxt.out_id_first  = key_rd[15:0];
			out_nxt.out_id_second = key_rd[31:16];
			out_nxt.out_id_third  = key_rd[47:32];
			out_nxt.out_timer_id  = key_rd[63:48];
			out_nxt.out_data      = data_rd;
			out_nxt.last          = $countones(due_q) == 1;
		end else begin
			case (cmd_q.op)
				OP_SET:   out_nxt.status = (found_q || free_q) ? ST_OK : ST_FULL;
				OP_KILL:  out_nxt.status = found_q ? ST_OK : ST_NOTFOUND;
				OP_ADD:   out_nxt.status = found_q ? ST_OK : ST_NOTFOUND;
				OP_QUERY: begin
					out_nxt.status    = found_q ? ST_OK : ST_NOTFOUND;
					out_nxt.remaining = found_q ? cnt_rd : 32'sd0;
				end
				default:  out_nxt.status = cmd_q.st;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			best_ok_q <= 1'b0;
			due_q     <= '0;
			valid_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						if (rd_entry.op == OP_STATUS) begin
							state_q <= S_EXEC;
						end else if (rd_entry.op == OP_TICK) begin
							state_q <= S_DEC;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					found_q    <= nxt_found;
					hit_q      <= nxt_hit;
					free_q     <= nxt_free;
					free_idx_q <= nxt_free_idx;
					if (at_last) begin
						idx_q   <= nxt_found ? nxt_hit : nxt_free_idx;
						state_q <= S_EXEC;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (cmd_q.op == OP_KILL && found_q) begin
							valid_q[idx_q] <= 1'b0;
						end
						if (cmd_q.op == OP_SET && (found_q || free_q)) begin
							valid_q[idx_q] <= 1'b1;
						end
					end
				end
				S_DEC: begin
					due_q[idx_q] <= dec_due;
					if (at_last) begin
						idx_q     <= '0;
						best_ok_q <= 1'b0;
						if ((|due_q) || dec_due) begin
							state_q <= S_MIN;
						end else begin
							state_q <= S_EXEC;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MIN: begin
					if (better) begin
						best_ok_q  <= 1'b1;
						best_key_q <= key_rd;
						best_q     <= idx_q;
					end
					if (at_last) begin
						idx_q   <= better ? idx_q : best_q;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						valid_q[idx_q] <= 1'b0;
						due_q[idx_q]   <= 1'b0;
						best_ok_q      <= 1'b0;
						if ($countones(due_q) == 1) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= '0;
							state_q <= S_MIN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command register, result register and slot contents.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= rd_entry;
		end
		if (state_q == S_DEC && at_last && !((|due_q) || dec_due)) begin
			cmd_q.op <= OP_STATUS;
			cmd_q.st <= ST_OK;
		end
		if (state_q == S_DEC && valid_q[idx_q]) begin
			cnt_mem[idx_q] <= dec_val;
		end
		if (state_q == S_EXEC && out_free) begin
			if (cmd_q.op == OP_SET && (found_q || free_q)) begin
				key_mem[idx_q]  <= cmd_q.key;
				cnt_mem[idx_q]  <= cmd_q.delay;
				data_mem[idx_q] <= cmd_q.data;
			end
			if (cmd_q.op == OP_ADD && found_q) begin
				cnt_mem[idx_q] <= sat_add(cnt_rd, cmd_q.delay);
			end
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

endmodule

### rtl/ktt_checker.sv
module ktt_checker
	import ktt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_t out_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_expiry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_EXPIRY |-> out_word.status == ST_OK
			&& out_word.remaining == 32'sd0)
		else $error("expiry word with status or count");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_STATUS |-> out_word.last
			&& out_word.out_data == 64'd0 && out_word.out_timer_id == 16'd0)
		else $error("status word carries timer fields");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != ST_OK |-> out_word.remaining == 32'sd0)
		else $error("failed command reports a count");

endmodule

bind keyed_oneshot_timer_table_top ktt_checker u_ktt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
